// File: hw/rtl/dlti_pkg.sv
`timescale 1ns / 1ps

package dlti_pkg;

	localparam int PID_W  = 5;
	localparam int KEY_W  = 16;
	localparam int LINK_W = 6;

	localparam logic [KEY_W-1:0] TAIL_KEY = '1;

	typedef logic [PID_W-1:0]  pid_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [LINK_W-1:0] link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_WR_NEW,
		ST_WR_LINK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic start;
		logic compare;
		logic advance;
		logic wr_new;
		logic wr_link;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic pid_bad;
		logic walk_more;
		logic out_free;
	} stat_t;

endpackage

// File: hw/rtl/dlti_in_if.sv
`timescale 1ns / 1ps

interface dlti_in_if;
	import dlti_pkg::*;

	logic valid;
	logic ready;
	pid_t process_id;
	key_t wait_ticks;

	modport source(output valid, output process_id, output wait_ticks, input ready);
	modport sink(input valid, input process_id, input wait_ticks, output ready);
endinterface

// File: hw/rtl/dlti_out_if.sv
`timescale 1ns / 1ps

interface dlti_out_if;
	import dlti_pkg::*;

	logic  valid;
	logic  ready;
	key_t  stored_delta;
	link_t predecessor;
	link_t successor;

	modport source(output valid, output stored_delta, output predecessor, output successor,
		input ready);
	modport sink(input valid, input stored_delta, input predecessor, input successor,
		output ready);
endinterface

// File: hw/rtl/dlti_ctrl.sv
`timescale 1ns / 1ps

module dlti_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  dlti_pkg::stat_t stat,
	output dlti_pkg::cmd_t  cmd
);
	import dlti_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					cmd.start = 1'b1;
					state_d   = stat.pid_bad ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				if (stat.walk_more) begin
					cmd.advance = 1'b1;
					state_d     = ST_READ;
				end else begin
					state_d = ST_WR_NEW;
				end
			end
			ST_WR_NEW: begin
				cmd.wr_new = 1'b1;
				state_d    = ST_WR_LINK;
			end
			ST_WR_LINK: begin
				cmd.wr_link = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/dlti_dp.sv
`timescale 1ns / 1ps

module dlti_dp #(
	parameter int NUM_PROCS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dlti_pkg::cmd_t  cmd,
	output dlti_pkg::stat_t stat,
	dlti_in_if.sink         request,
	dlti_out_if.source      result
);
	import dlti_pkg::*;

	localparam int STORE_DEPTH = NUM_PROCS + 2;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int HEAD_IDX    = NUM_PROCS;
	localparam int TAIL_IDX    = NUM_PROCS + 1;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t HEAD = IDX_W'(HEAD_IDX);
	localparam idx_t TAIL = IDX_W'(TAIL_IDX);

	function automatic idx_t fix_index(input idx_t i);
		return (32'(i) < STORE_DEPTH) ? i : '0;
	endfunction

	idx_t fwd_mem [STORE_DEPTH];
	idx_t bwd_mem [STORE_DEPTH];
	key_t key_mem [STORE_DEPTH];

	idx_t  fwd_rd_q;
	key_t  key_rd_q;
	idx_t  head_q;
	idx_t  steps_q;
	logic  bad_q;
	logic  out_valid_q;
	idx_t  pid_q;
	idx_t  prev_q;
	idx_t  next_q;
	key_t  remain_q;
	key_t  key_hold_q;
	key_t  out_delta_q;
	link_t out_pred_q;
	link_t out_succ_q;

	key_t key_cur;
	key_t link_key;

	assign key_cur  = (next_q == TAIL) ? TAIL_KEY : key_rd_q;
	assign link_key = ((next_q == pid_q) || (key_hold_q < remain_q)) ? '0
		: key_t'(key_hold_q - remain_q);

	assign stat.in_valid  = request.valid;
	assign stat.pid_bad   = 32'(request.process_id) >= NUM_PROCS;
	assign stat.walk_more = (key_cur < remain_q) && (32'(steps_q) < NUM_PROCS + 1);
	assign stat.out_free  = !out_valid_q || result.ready;

	assign request.ready       = cmd.in_ready;
	assign result.valid        = out_valid_q;
	assign result.stored_delta = out_delta_q;
	assign result.predecessor  = out_pred_q;
	assign result.successor    = out_succ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= TAIL;
			steps_q     <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				steps_q <= '0;
				bad_q   <= stat.pid_bad;
			end else if (cmd.advance) begin
				steps_q <= idx_t'(steps_q + 1'b1);
			end
			if (cmd.wr_link && (prev_q == HEAD)) begin
				head_q <= pid_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pid_q    <= IDX_W'(request.process_id);
			remain_q <= request.wait_ticks;
			prev_q   <= HEAD;
			next_q   <= fix_index(head_q);
		end else if (cmd.advance) begin
			remain_q <= key_t'(remain_q - key_cur);
			prev_q   <= next_q;
			next_q   <= fix_index(fwd_rd_q);
		end
		if (cmd.compare) begin
			key_hold_q <= key_cur;
		end
		if (cmd.load_out) begin
			out_delta_q <= bad_q ? '0 : remain_q;
			out_pred_q  <= bad_q ? '0 : LINK_W'(prev_q);
			out_succ_q  <= bad_q ? '0 : LINK_W'(next_q);
		end
	end

	always_ff @(posedge clk) begin
		fwd_rd_q <= fwd_mem[next_q];
		key_rd_q <= key_mem[next_q];
		if (cmd.wr_new) begin
			fwd_mem[pid_q] <= next_q;
			bwd_mem[pid_q] <= prev_q;
			key_mem[pid_q] <= remain_q;
		end
		if (cmd.wr_link) begin
			if (prev_q != HEAD) begin
				fwd_mem[prev_q] <= pid_q;
			end
			bwd_mem[next_q] <= pid_q;
			if (32'(next_q) < NUM_PROCS) begin
				key_mem[next_q] <= link_key;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) < STORE_DEPTH) && (head_q != HEAD))
		else $error("head link out of range");

	a_advance_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> remain_q <= $past(remain_q))
		else $error("remaining wait grew during walk");

	a_advance_links: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> prev_q == $past(next_q))
		else $error("walk lost predecessor");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> 32'(steps_q) < NUM_PROCS + 1)
		else $error("walk exceeded entry count");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result word not presented");
`endif

endmodule

// File: hw/rtl/delta_list_timer_insert_unit.sv
`timescale 1ns / 1ps

// Inserts a process into a delta-ordered sleep list held as a doubly linked list in an
// on-chip entry store (NUM_PROCS process entries plus head and tail). One request is
// handled at a time: after a request word is taken, the unit walks the list from the head,
// visiting each entry with a registered store read followed by a compare and subtract,
// including the entry it stops at (at most NUM_PROCS+2 entries), then writes the store
// (the new entry, then its neighbours) and loads the result register. A process number
// at or above NUM_PROCS skips the walk, leaves the list unchanged and returns an all-zero
// result. The result register lets the next request be taken while a result waits. The
// list is ready for use right after reset; no clearing pass is needed.
module delta_list_timer_insert_unit #(
	parameter int NUM_PROCS = 32
) (
	input logic        clk,
	input logic        arst_n,
	dlti_in_if.sink    request,
	dlti_out_if.source result
);
	import dlti_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dlti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	dlti_dp #(
		.NUM_PROCS (NUM_PROCS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.request (request),
		.result  (result)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import dlti_pkg::*;

	localparam int NUM_PROCS = 32;
	localparam int HEAD_IDX  = NUM_PROCS;
	localparam int TAIL_IDX  = NUM_PROCS + 1;
	localparam int STORE_N   = NUM_PROCS + 2;
	localparam int DRAIN_CYCLES = 2 * STORE_N + 12;

	typedef struct {
		pid_t  pid;
		key_t  delta;
		link_t pred;
		link_t succ;
	} placement_t;

	logic clk = 1'b0;
	logic arst_n;

	dlti_in_if  request_bus ();
	dlti_out_if result_bus ();

	delta_list_timer_insert_unit #(
		.NUM_PROCS(NUM_PROCS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_bus),
		.result (result_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	link_t      fwd_link [STORE_N];
	link_t      bwd_link [STORE_N];
	key_t       delta_of [STORE_N];
	placement_t pending_q[$];
	int         mismatches = 0;
	bit         gaps_on = 1'b1;

	function automatic int bound_idx(input int idx);
		return (idx < STORE_N) ? idx : 0;
	endfunction

	function automatic placement_t place_process(input pid_t pid, input key_t ticks);
		placement_t p;
		int remain;
		int prev;
		int nxt;
		int hops;
		p.pid   = pid;
		p.delta = '0;
		p.pred  = '0;
		p.succ  = '0;
		if (int'(pid) >= NUM_PROCS)
			return p;
		remain = ticks;
		prev   = HEAD_IDX;
		nxt    = bound_idx(fwd_link[HEAD_IDX]);
		hops   = 0;
		while (int'(delta_of[nxt]) < remain && hops < NUM_PROCS + 1) begin
			remain -= delta_of[nxt];
			prev    = nxt;
			nxt     = bound_idx(fwd_link[nxt]);
			hops++;
		end
		// keep this write order: it decides the outcome when the list is corrupted
		fwd_link[pid]  = link_t'(nxt);
		bwd_link[pid]  = link_t'(prev);
		delta_of[pid]  = key_t'(remain);
		fwd_link[prev] = link_t'(pid);
		bwd_link[nxt]  = link_t'(pid);
		if (nxt < NUM_PROCS)
			delta_of[nxt] = (int'(delta_of[nxt]) >= remain) ? key_t'(delta_of[nxt] - remain) : '0;
		p.delta = key_t'(remain);
		p.pred  = link_t'(prev);
		p.succ  = link_t'(nxt);
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic key_t pick_ticks();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'hFFFE;
			3, 4: return key_t'($urandom_range(0, 255));
			default: return key_t'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_request(input pid_t pid, input key_t ticks);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			request_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_bus.valid      <= 1'b1;
		request_bus.process_id <= pid;
		request_bus.wait_ticks <= ticks;
		do @(posedge clk); while (request_bus.ready !== 1'b1);
		pending_q.push_back(place_process(pid, ticks));
	endtask

	// hold ready low for random stretches
	initial begin
		int stall_left;
		stall_left = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				result_bus.ready <= (stall_left == 0);
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		placement_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: delta=%0d pred=%0d succ=%0d",
						result_bus.stored_delta, result_bus.predecessor, result_bus.successor);
			end else begin
				want = pending_q.pop_front();
				if (result_bus.stored_delta !== want.delta || result_bus.predecessor !== want.pred ||
						result_bus.successor !== want.succ) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch pid=%0d: exp delta=%0d pred=%0d succ=%0d, got delta=%0d pred=%0d succ=%0d",
							want.pid, want.delta, want.pred, want.succ, result_bus.stored_delta,
							result_bus.predecessor, result_bus.successor);
				end
			end
		end
	end

	task automatic test_extremes();
		gaps_on = 1'b0;
		send_request(5'd0, 16'd0);
		send_request(5'd31, 16'hFFFF);
		send_request(5'd1, 16'd0);
		send_request(5'd2, 16'hFFFE);
		send_request(5'd3, 16'd1);
		send_request(5'd4, 16'd100);
		send_request(5'd5, 16'd100);
		send_request(5'd6, 16'd50);
		send_request(5'd7, 16'h8000);
		send_request(5'd8, 16'h7FFF);
	endtask

	task automatic test_fill_distinct();
		int pool[$];
		int j;
		int t;
		for (int i = 9; i < 31; i++)
			pool.push_back(i);
		for (int i = pool.size() - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			t       = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		gaps_on = 1'b1;
		foreach (pool[i])
			send_request(pid_t'(pool[i]), pick_ticks());
	endtask

	task automatic test_reinsert();
		send_request(5'd31, 16'hFFFF);
		send_request(5'd3, 16'd0);
		send_request(5'd15, 16'd1234);
		send_request(5'd0, 16'hFFFE);
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < 815; n++) begin
			if (n % 50 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			send_request(pid_t'($urandom_range(0, NUM_PROCS - 1)), pick_ticks());
		end
	endtask

	initial begin
		foreach (fwd_link[i]) begin
			fwd_link[i] = '0;
			bwd_link[i] = '0;
			delta_of[i] = '0;
		end
		fwd_link[HEAD_IDX] = link_t'(TAIL_IDX);
		bwd_link[TAIL_IDX] = link_t'(HEAD_IDX);
		delta_of[TAIL_IDX] = TAIL_KEY;

		arst_n                 = 1'b0;
		request_bus.valid      = 1'b0;
		request_bus.process_id = '0;
		request_bus.wait_ticks = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_fill_distinct();
		test_reinsert();
		test_random_traffic();

		request_bus.valid <= 1'b0;
		gaps_on = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout waiting for handshake");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/dlti_pkg.sv
hw/rtl/dlti_in_if.sv
hw/rtl/dlti_out_if.sv
hw/rtl/dlti_ctrl.sv
hw/rtl/dlti_dp.sv
hw/rtl/delta_list_timer_insert_unit.sv
bench/tb.sv
